/* sv/prrt_pkg.sv */
// prrt_pkg: shared types and constants for the page region reservation table
// item structs, command and status codes, default sizes
// no dependencies
package prrt_pkg;

    localparam int ADDR_W  = 48;
    localparam int PAGES_W = 20;
    localparam int STAT_W  = 2;

    localparam int DEF_MAX_REGIONS    = 16;
    localparam int DEF_PAGE_SIZE_LOG2 = 12;

    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    localparam logic CMD_CLAIM   = 1'b0;
    localparam logic CMD_CORRECT = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_CONFLICT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT      = 2'd3;

    typedef struct packed {
        logic               command;
        logic [ADDR_W-1:0]  start_address;
        logic [PAGES_W-1:0] page_count;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic [STAT_W-1:0]  status;
        logic [ADDR_W-1:0]  corrected_address;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [PAGES_W-1:0] pages;
    } entry_t;

endpackage

/* sv/page_region_reservation_table.sv */
// flow: an item is taken in S_IDLE; with stored regions, S_WALK reads the region memory,
// one entry read per cycle, and checks each entry; S_DONE then loads the result once the
// output is free (an empty table goes straight to S_DONE); the next item is taken only
// after the result of the last one is loaded, so a result held by rsp_ready stalls intake
// reset: asynchronous, clears the region count, the sequencer and the result valid;
// region memory contents are left as they are and never read before written
module page_region_reservation_table #(
    parameter int MAX_REGIONS    = prrt_pkg::DEF_MAX_REGIONS,
    parameter int PAGE_SIZE_LOG2 = prrt_pkg::DEF_PAGE_SIZE_LOG2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  prrt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output prrt_pkg::rsp_t rsp
);
    import prrt_pkg::*;

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int LEN_W = PAGES_W + PAGE_SIZE_LOG2;
    localparam int END_W = ((LEN_W > ADDR_W) ? LEN_W : ADDR_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // control
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_reg, pend_next;
    logic             flag_reg, flag_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload
    logic              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PAGES_W-1:0] pages_reg;
    logic [END_W-1:0]  new_end_reg;
    logic [ADDR_W-1:0] run_reg, run_next;
    rsp_t              rsp_reg, rsp_next;

    entry_t mem [MAX_REGIONS];
    entry_t rd_data_reg;

    logic             accept;
    logic             issue;
    logic             load_rsp;
    logic             mem_we;
    logic             full;
    logic [END_W-1:0] rd_len;
    logic [END_W-1:0] rd_end;
    logic [END_W-1:0] run_sum;
    logic             hit_claim;
    logic             hit_run;
    logic             over;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign issue     = (idx_reg != count_reg);
    assign full      = (count_reg == CNT_W'(MAX_REGIONS));

    assign rd_len  = END_W'(rd_data_reg.pages) << PAGE_SIZE_LOG2;
    assign rd_end  = END_W'(rd_data_reg.start) + rd_len;
    assign run_sum = END_W'(run_reg) + rd_len;
    assign over    = (run_sum > END_W'(ADDR_MAX));
    assign hit_run = (rd_data_reg.start == run_reg);
    // equal start, or the two byte ranges overlap
    assign hit_claim = (rd_data_reg.start == addr_reg)
                    || ((END_W'(addr_reg) < rd_end) && (END_W'(rd_data_reg.start) < new_end_reg));

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        pend_next      = 1'b0;
        flag_next      = flag_reg;
        run_next       = run_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        load_rsp       = 1'b0;
        mem_we         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    idx_next   = '0;
                    flag_next  = 1'b0;
                    run_next   = req.start_address;
                    state_next = (count_reg == '0) ? S_DONE : S_WALK;
                end
            end
            S_WALK:
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (cmd_reg == CMD_CLAIM)
                    begin
                        if (hit_claim)
                        begin
                            flag_next = 1'b1;
                        end
                    end
                    else if (hit_run)
                    begin
                        if (over)
                        begin
                            run_next  = ADDR_MAX;
                            flag_next = 1'b1;
                        end
                        else
                        begin
                            run_next = run_sum[ADDR_W-1:0];
                        end
                    end
                end
                // last read is consumed in this cycle
                if (!issue)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    load_rsp       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if ((cmd_reg == CMD_CLAIM) && !flag_reg && !full)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next = '0;
        if (cmd_reg == CMD_CLAIM)
        begin
            rsp_next.granted = !flag_reg && !full;
            if (flag_reg)
            begin
                rsp_next.status = ST_CONFLICT;
            end
            else if (full)
            begin
                rsp_next.status = ST_FULL;
            end
            else
            begin
                rsp_next.status = ST_OK;
            end
        end
        else
        begin
            rsp_next.status            = flag_reg ? ST_SAT : ST_OK;
            rsp_next.corrected_address = run_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            flag_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            flag_reg      <= flag_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        if (accept)
        begin
            cmd_reg     <= req.command;
            addr_reg    <= req.start_address;
            pages_reg   <= req.page_count;
            new_end_reg <= END_W'(req.start_address) + (END_W'(req.page_count) << PAGE_SIZE_LOG2);
        end
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // region memory, one read port registered, one write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{start: addr_reg, pages: pages_reg};
        end
        if ((state_reg == S_WALK) && issue)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* sv/prrt_checker.sv */
// prrt_checker: port-level checks on the page region reservation table
// bound to page_region_reservation_table; depends on prrt_pkg
module prrt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input prrt_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input prrt_pkg::rsp_t rsp
);
    import prrt_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // one item at a time: no item taken right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while previous one in progress");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.granted |-> rsp.status == ST_OK && rsp.corrected_address == '0)
        else $error("granted claim with bad status or address");

    // a saturated walk always ends clamped
    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_SAT |-> rsp.corrected_address == ADDR_MAX && !rsp.granted)
        else $error("saturated result not clamped");

endmodule

bind page_region_reservation_table prrt_checker u_prrt_checker (.*);

/* bench/reservation_checker.sv */
// reservation_checker: watches both channels of the page region reservation table,
// keeps its own copy of the region table and checks every result item in order
// depends on prrt_pkg
module reservation_checker #(
    parameter int MAX_REGIONS    = prrt_pkg::DEF_MAX_REGIONS,
    parameter int PAGE_SIZE_LOG2 = prrt_pkg::DEF_PAGE_SIZE_LOG2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  prrt_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  prrt_pkg::rsp_t rsp,
    output int             mismatches,
    output int             awaited
);
    import prrt_pkg::*;

    logic [ADDR_W-1:0]  held_start [MAX_REGIONS];
    logic [PAGES_W-1:0] held_pages [MAX_REGIONS];
    int                 held_count;
    rsp_t               awaited_rsps [$];

    initial mismatches = 0;
    initial awaited = 0;

    function automatic logic [63:0] region_bytes(input logic [PAGES_W-1:0] pages);
        return {{(64-PAGES_W){1'b0}}, pages} << PAGE_SIZE_LOG2;
    endfunction

    // updates the held table and works out the result item for one command
    task automatic apply_command(input req_t item, output rsp_t outcome);
        logic [63:0] addr_x;
        logic [63:0] new_end;
        logic [63:0] reg_lo;
        logic [63:0] reg_hi;
        logic [63:0] running;
        logic        clash;
        logic        clamped;
        begin
            outcome = '0;
            outcome.status = ST_OK;
            addr_x = {{(64-ADDR_W){1'b0}}, item.start_address};
            if (item.command == CMD_CLAIM) begin
                new_end = addr_x + region_bytes(item.page_count);
                clash = 1'b0;
                for (int i = 0; i < held_count; i++) begin
                    reg_lo = {{(64-ADDR_W){1'b0}}, held_start[i]};
                    reg_hi = reg_lo + region_bytes(held_pages[i]);
                    if (reg_lo == addr_x || (addr_x < reg_hi && reg_lo < new_end))
                        clash = 1'b1;
                end
                if (clash)
                    outcome.status = ST_CONFLICT;
                else if (held_count >= MAX_REGIONS)
                    outcome.status = ST_FULL;
                else
                begin
                    held_start[held_count] = item.start_address;
                    held_pages[held_count] = item.page_count;
                    held_count++;
                    outcome.granted = 1'b1;
                end
            end
            else
            begin
                running = addr_x;
                clamped = 1'b0;
                for (int i = 0; i < held_count; i++) begin
                    if ({{(64-ADDR_W){1'b0}}, held_start[i]} == running) begin
                        running = running + region_bytes(held_pages[i]);
                        // clamp at the top of the address space, the walk carries on
                        if (running > {{(64-ADDR_W){1'b0}}, ADDR_MAX}) begin
                            running = {{(64-ADDR_W){1'b0}}, ADDR_MAX};
                            clamped = 1'b1;
                        end
                    end
                end
                outcome.corrected_address = running[ADDR_W-1:0];
                if (clamped)
                    outcome.status = ST_SAT;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        begin
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n) begin
            held_count = 0;
            awaited_rsps.delete();
            awaited <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready) begin
                if (awaited_rsps.size() == 0)
                    report_mismatch("result item with none awaited", 64'(rsp), 64'd0);
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (rsp.granted !== want.granted)
                        report_mismatch("granted", 64'(rsp.granted), 64'(want.granted));
                    if (rsp.status !== want.status)
                        report_mismatch("status", 64'(rsp.status), 64'(want.status));
                    if (rsp.corrected_address !== want.corrected_address)
                        report_mismatch("corrected_address", 64'(rsp.corrected_address),
                                        64'(want.corrected_address));
                end
            end
            if (req_valid && req_ready) begin
                apply_command(req, want);
                awaited_rsps.push_back(want);
            end
            awaited <= awaited_rsps.size();
        end
    end

endmodule

/* bench/testbench.sv */
// testbench: drives command items into the page region reservation table with bursty
// offers and a stalling receiver; checking is left to reservation_checker
// depends on prrt_pkg, page_region_reservation_table and reservation_checker
module testbench;
    import prrt_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int PAGE_SHIFT   = DEF_PAGE_SIZE_LOG2;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    int   mismatches;
    int   awaited;

    // sender burst state and the long receiver hold-off handshake
    int   burst_left   = 0;
    bit   hold_off_go  = 1'b0;
    bit   held_off     = 1'b0;

    // regions known to be stored, used to aim random items at real boundaries
    logic [ADDR_W-1:0]  anchor_start [$];
    logic [PAGES_W-1:0] anchor_pages [$];

    page_region_reservation_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    reservation_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic req_t make_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                                       input logic [PAGES_W-1:0] pages);
        req_t item;
        item.command       = cmd;
        item.start_address = addr;
        item.page_count    = pages;
        return item;
    endfunction

    function automatic logic [PAGES_W-1:0] random_pages();
        logic [PAGES_W-1:0] pages;
        case ($urandom_range(0, 5))
            0, 1, 2: pages = PAGES_W'($urandom_range(0, 16));
            3:       pages = PAGES_W'($urandom);
            4:       pages = {PAGES_W{1'b1}};
            default: pages = PAGES_W'($urandom_range(0, 1));
        endcase
        return pages;
    endfunction

    // mostly items aimed at stored starts, ends and interiors, the rest noise
    function automatic req_t random_item();
        int                 idx;
        logic [ADDR_W-1:0]  base;
        logic [63:0]        span;
        logic [63:0]        noise;
        logic [PAGES_W-1:0] pages;
        logic [ADDR_W-1:0]  addr;
        logic               cmd;
        idx   = $urandom_range(0, anchor_start.size() - 1);
        base  = anchor_start[idx];
        span  = {{(64-PAGES_W){1'b0}}, anchor_pages[idx]} << PAGE_SHIFT;
        noise = {$urandom, $urandom};
        pages = random_pages();
        cmd   = CMD_CLAIM;
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                cmd  = CMD_CORRECT;
                addr = base;
            end
            3:
            begin
                cmd  = CMD_CORRECT;
                addr = base + span[ADDR_W-1:0];
            end
            4:
            begin
                cmd  = CMD_CORRECT;
                addr = noise[ADDR_W-1:0];
            end
            5:
            begin
                cmd  = CMD_CORRECT;
                addr = {16'hFFFF, noise[31:0]};
            end
            6: addr = base;
            7: addr = (span == 0) ? base : base + ADDR_W'(noise % span);
            8: addr = base + span[ADDR_W-1:0];
            // ends exactly where a stored region starts
            9: addr = base - ADDR_W'({{(64-PAGES_W){1'b0}}, pages} << PAGE_SHIFT);
            10: addr = noise[ADDR_W-1:0];
            default:
            begin
                cmd   = noise[63];
                addr  = noise[ADDR_W-1:0];
                pages = PAGES_W'($urandom);
            end
        endcase
        return make_item(cmd, addr, pages);
    endfunction

    // offers one item and returns at the edge where it is taken
    task automatic offer(input req_t item);
        int gap;
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            req       <= item;
            req_valid <= 1'b1;
            @(posedge clk);
            while (!req_ready) @(posedge clk);
        end
    endtask

    task automatic claim_anchor(input logic [ADDR_W-1:0] addr,
                                input logic [PAGES_W-1:0] pages);
        begin
            anchor_start.push_back(addr);
            anchor_pages.push_back(pages);
            offer(make_item(CMD_CLAIM, addr, pages));
        end
    endtask

    task automatic drain();
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while (awaited != 0) @(posedge clk);
        end
    endtask

    // receiver: stretches of steady, light and heavy stalling, plus one long hold-off
    initial
    begin : receiver
        int mode;
        int span;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_go && !held_off) begin
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
                held_off = 1'b1;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 120);
            repeat (span) begin
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [ADDR_W-1:0]  chain_addr;
        logic [PAGES_W-1:0] chain_pages;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // equal start, zero-length regions, interior and touching boundaries
        claim_anchor(48'h0, 20'd1);
        offer(make_item(CMD_CLAIM, 48'h0, 20'd5));
        claim_anchor(48'h1000, 20'd0);
        offer(make_item(CMD_CLAIM, 48'h800, 20'd0));
        offer(make_item(CMD_CLAIM, 48'h1000, 20'd3));
        claim_anchor(48'h1000_0000, {PAGES_W{1'b1}});
        offer(make_item(CMD_CLAIM, 48'h0FFF_F000, 20'd2));
        claim_anchor(48'h0FFF_F000, 20'd1);
        // region running past the top of the address space
        claim_anchor(ADDR_MAX - 48'hFFF, {PAGES_W{1'b1}});
        offer(make_item(CMD_CLAIM, ADDR_MAX, 20'd0));
        offer(make_item(CMD_CORRECT, 48'h0, {PAGES_W{1'b1}}));
        offer(make_item(CMD_CORRECT, 48'h0FFF_F000, 20'd0));
        offer(make_item(CMD_CORRECT, ADDR_MAX - 48'hFFF, 20'd7));
        offer(make_item(CMD_CORRECT, ADDR_MAX, 20'd0));

        // fill the rest of the table with a contiguous chain in ascending order
        chain_addr = 48'h0002_0000_0000;
        for (int k = anchor_start.size(); k < DEF_MAX_REGIONS; k++) begin
            chain_pages = PAGES_W'($urandom_range(1, 16));
            claim_anchor(chain_addr, chain_pages);
            chain_addr = chain_addr + (ADDR_W'(chain_pages) << PAGE_SHIFT);
        end
        offer(make_item(CMD_CORRECT, 48'h0002_0000_0000, 20'd0));
        // full table, then a clash that must win over full
        offer(make_item(CMD_CLAIM, 48'h8000_0000_0000, 20'd4));
        offer(make_item(CMD_CLAIM, 48'h0, 20'd1));

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 150)
                hold_off_go = 1'b1;
            if (k == 350) begin
                drain();
                burst_left = 0;
            end
            offer(random_item());
        end

        drain();
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
sv/prrt_pkg.sv
sv/page_region_reservation_table.sv
sv/prrt_checker.sv
bench/reservation_checker.sv
bench/testbench.sv
